### sv/lz77_backref_copy_engine_top_defines.svh
// Assertion macros for the LZ77 copy engine checker.
`ifndef LZ77_BACKREF_COPY_ENGINE_TOP_DEFINES_SVH
`define LZ77_BACKREF_COPY_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every edge outside reset.
`define LZBC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lzbc assertion failed");

// Next-cycle implication, checked on every edge outside reset.
`define LZBC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lzbc assertion failed");

`endif

### sv/lzbc_pkg.sv
// Shared types and constants of the LZ77 copy engine.
package lzbc_pkg;

  localparam int LEN_W  = 9;
  localparam int DIST_W = 16;

  localparam logic [1:0] OP_LIT   = 2'd0;
  localparam logic [1:0] OP_MATCH = 2'd1;
  localparam logic [1:0] OP_EOB   = 2'd2;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_DIST_SYM = 2'd1;
  localparam logic [1:0] ERR_DIST_FAR = 2'd2;

  localparam logic [8:0] LSYM_MIN     = 9'd257;
  localparam logic [8:0] LSYM_EXTRA   = 9'd265;
  localparam logic [8:0] LSYM_MAX     = 9'd285;
  localparam logic [8:0] LEN_BIAS     = 9'd254;
  localparam logic [8:0] LEN_MAX      = 9'd258;
  localparam logic [8:0] LEN_BASE_ADD = 9'd3;
  localparam logic [4:0] DSYM_DIRECT  = 5'd4;
  localparam logic [4:0] DSYM_MAX     = 5'd29;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SINGLE,
    S_COPY
  } state_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [DIST_W-1:0] distance;
    logic              len_ok;
    logic              dsym_bad;
  } dec_t;

  typedef struct packed {
    logic       load_single;
    logic       single_lit;
    logic       single_blk;
    logic [1:0] single_err;
    logic       absorb;
    logic       final_byte;
  } pack_ctl_t;

  typedef struct packed {
    logic can_take;
    logic out_free;
  } pack_sts_t;

endpackage

### sv/lzbc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lzbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/lzbc_decode.sv
// Length and distance symbol decoder, registered on token accept.
module lzbc_decode import lzbc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [8:0]  length_symbol,
  input  logic [4:0]  length_extra,
  input  logic [4:0]  distance_symbol,
  input  logic [12:0] distance_extra,
  output dec_t        dec
);

  logic [8:0]        off;
  logic [2:0]        lbits;
  logic [4:0]        lmask;
  logic [7:0]        lbase;
  logic [3:0]        dbits;
  logic [13:0]       dmask;
  logic [DIST_W-1:0] dbase;
  dec_t              dec_next;

  always_comb begin
    off   = length_symbol - LSYM_EXTRA;
    lbits = 3'(off[4:2]) + 3'd1;
    lmask = 5'((6'd1 << lbits) - 6'd1);
    lbase = 8'({1'b1, off[1:0]}) << lbits;
    dbits = 4'(distance_symbol[4:1]) - 4'd1;
    dmask = 14'((15'd1 << dbits) - 15'd1);
    dbase = DIST_W'({1'b1, distance_symbol[0]}) << dbits;

    dec_next.len_ok   = (length_symbol >= LSYM_MIN) && (length_symbol <= LSYM_MAX);
    dec_next.dsym_bad = distance_symbol > DSYM_MAX;

    if (length_symbol == LSYM_MAX) begin
      dec_next.len = LEN_MAX;
    end else if (length_symbol < LSYM_EXTRA) begin
      dec_next.len = length_symbol - LEN_BIAS;
    end else begin
      dec_next.len = {1'b0, lbase} + LEN_BASE_ADD + {4'b0, length_extra & lmask};
    end

    if (distance_symbol < DSYM_DIRECT) begin
      dec_next.distance = DIST_W'(distance_symbol) + DIST_W'(1);
    end else begin
      dec_next.distance = dbase + DIST_W'(1) + DIST_W'({1'b0, distance_extra} & dmask);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec <= dec_next;
    end
  end

endmodule

### sv/lzbc_pack.sv
// Byte packer and output word register.
module lzbc_pack import lzbc_pkg::*; #(
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  pack_ctl_t   ctl,
  input  logic [7:0]  lit,
  input  logic [7:0]  data,
  output pack_sts_t   sts,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_bytes,
  output logic [3:0]  byte_count,
  output logic        last,
  output logic        block_end,
  output logic [1:0]  error_code
);

  localparam int FW = (BYTES_PER_RESULT > 1) ? $clog2(BYTES_PER_RESULT) : 1;

  logic [8*BYTES_PER_RESULT-1:0] acc;
  logic [FW-1:0]                 fill;
  logic [63:0]                   word;
  logic                          completing;
  logic                          load_word;

  assign completing   = ctl.final_byte || (fill == FW'(BYTES_PER_RESULT - 1));
  assign sts.out_free = !out_valid || !out_stall;
  assign sts.can_take = !completing || sts.out_free;
  assign load_word    = ctl.absorb && completing;

  always_comb begin
    word = '0;
    for (int j = 0; j < BYTES_PER_RESULT; j++) begin
      if (FW'(j) < fill) begin
        word[8*j +: 8] = acc[8*j +: 8];
      end else if (FW'(j) == fill) begin
        word[8*j +: 8] = data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.absorb) begin
        fill <= completing ? '0 : fill + 1'b1;
      end
      if (ctl.load_single || load_word) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.absorb && !completing) begin
      for (int j = 0; j < BYTES_PER_RESULT; j++) begin
        if (FW'(j) == fill) begin
          acc[8*j +: 8] <= data;
        end
      end
    end
    if (ctl.load_single) begin
      out_bytes  <= ctl.single_lit ? 64'(lit) : '0;
      byte_count <= ctl.single_lit ? 4'd1 : 4'd0;
      last       <= 1'b1;
      block_end  <= ctl.single_blk;
      error_code <= ctl.single_err;
    end else if (load_word) begin
      out_bytes  <= word;
      byte_count <= 4'(fill) + 4'd1;
      last       <= ctl.final_byte;
      block_end  <= 1'b0;
      error_code <= ERR_OK;
    end
  end

endmodule

### sv/lz77_backref_copy_engine_top.sv
// LZ77 back-reference copy engine: token sequencer, history window and output packing.
//
//   channel | dir | handshake           | words
//   in      | in  | in_valid / in_stall | one token (literal, match, end of block)
//   out     | out | out_valid/out_stall | up to BYTES_PER_RESULT bytes, flags, error
//
// A literal, end-of-block or rejected token passes through the check and single states
// before out_valid rises; the next token is taken once the engine is back in idle.
// A match runs through the check and copy states from accept to the next accept: the window RAM's one
// read port moves one byte a cycle when the output is not stalled.
// Output stalls pause the byte loop once a full word waits and hold back a single result;
// the next token is taken once the last byte is packed.
// Reset clears the state, pointer, window count, valid flags and fill level; the window RAM is not cleared.
module lz77_backref_copy_engine_top import lzbc_pkg::*; #(
  parameter int WINDOW_BYTES     = 32768,
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [7:0]  literal_byte,
  input  logic [8:0]  length_symbol,
  input  logic [4:0]  length_extra,
  input  logic [4:0]  distance_symbol,
  input  logic [12:0] distance_extra,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_bytes,
  output logic [3:0]  byte_count,
  output logic        last,
  output logic        block_end,
  output logic [1:0]  error_code
);

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int VW = $clog2(WINDOW_BYTES + 1);

  state_t           state, state_next;
  dec_t             dec;
  pack_ctl_t        ctl;
  pack_sts_t        sts;
  logic [1:0]       op_r;
  logic [7:0]       lit_r;
  logic [1:0]       err_r;
  logic [AW-1:0]    wp, wp_next, rd_addr, rd_inc, rd_start;
  logic [VW-1:0]    avail;
  logic [16:0]      rd_diff;
  logic [LEN_W-1:0] rd_left, wr_left;
  logic             rv, has_prev, dist_one;
  logic [7:0]       last_byte, rdata, byte_val;
  logic             in_acc, far, go_copy, absorb, issue, we;
  logic [1:0]       err_calc;

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;

  lzbc_decode u_dec (
    .clk             (clk),
    .en              (in_acc),
    .length_symbol   (length_symbol),
    .length_extra    (length_extra),
    .distance_symbol (distance_symbol),
    .distance_extra  (distance_extra),
    .dec             (dec)
  );

  assign far      = {1'b0, dec.distance} > 17'(avail);
  assign rd_diff  = 17'(wp) - 17'(dec.distance);
  assign rd_start = rd_diff[16] ? AW'(rd_diff + 17'(WINDOW_BYTES)) : AW'(rd_diff);
  assign go_copy  = (op_r == OP_MATCH) && dec.len_ok && !dec.dsym_bad && !far;

  always_comb begin
    err_calc = ERR_OK;
    if ((op_r == OP_MATCH) && dec.len_ok) begin
      if (dec.dsym_bad) begin
        err_calc = ERR_DIST_SYM;
      end else if (far) begin
        err_calc = ERR_DIST_FAR;
      end
    end
  end

  assign wp_next  = (wp == AW'(WINDOW_BYTES - 1)) ? '0 : wp + 1'b1;
  assign rd_inc   = (rd_addr == AW'(WINDOW_BYTES - 1)) ? '0 : rd_addr + 1'b1;
  assign byte_val = (dist_one && has_prev) ? last_byte : rdata;
  assign absorb   = (state == S_COPY) && rv && sts.can_take;
  assign issue    = (state == S_COPY) && (rd_left != '0) && (!rv || absorb);
  assign we       = ((state == S_CHECK) && (op_r == OP_LIT)) || absorb;

  always_comb begin
    state_next      = state;
    ctl.load_single = 1'b0;
    ctl.single_lit  = (op_r == OP_LIT);
    ctl.single_blk  = (op_r == OP_EOB);
    ctl.single_err  = err_r;
    ctl.absorb      = absorb;
    ctl.final_byte  = (wr_left == LEN_W'(1));
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = go_copy ? S_COPY : S_SINGLE;
      end
      S_SINGLE: begin
        if (sts.out_free) begin
          ctl.load_single = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_COPY: begin
        if (absorb && ctl.final_byte) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wp    <= '0;
      avail <= '0;
      rv    <= 1'b0;
    end else begin
      state <= state_next;
      if (we) begin
        wp <= wp_next;
        if (avail != VW'(WINDOW_BYTES)) begin
          avail <= avail + 1'b1;
        end
      end
      if (issue) begin
        rv <= 1'b1;
      end else if (absorb) begin
        rv <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= opcode;
      lit_r <= literal_byte;
    end
    if (state == S_CHECK) begin
      err_r    <= err_calc;
      rd_addr  <= rd_start;
      rd_left  <= dec.len;
      wr_left  <= dec.len;
      dist_one <= (dec.distance == DIST_W'(1));
      has_prev <= 1'b0;
    end else begin
      if (issue) begin
        rd_addr <= rd_inc;
        rd_left <= rd_left - 1'b1;
      end
      if (absorb) begin
        wr_left   <= wr_left - 1'b1;
        last_byte <= byte_val;
        has_prev  <= 1'b1;
      end
    end
  end

  lzbc_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_BYTES)
  ) u_win (
    .clk   (clk),
    .we    (we),
    .waddr (wp),
    .wdata (absorb ? byte_val : lit_r),
    .re    (issue),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  lzbc_pack #(
    .BYTES_PER_RESULT (BYTES_PER_RESULT)
  ) u_pack (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .lit        (lit_r),
    .data       (byte_val),
    .sts        (sts),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_bytes  (out_bytes),
    .byte_count (byte_count),
    .last       (last),
    .block_end  (block_end),
    .error_code (error_code)
  );

endmodule

### sv/lzbc_checker.sv
// Port-level checker for the LZ77 copy engine, bound to the top level.
`include "lz77_backref_copy_engine_top_defines.svh"

module lzbc_checker import lzbc_pkg::*; #(
  parameter int BYTES_PER_RESULT = 8
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_bytes,
  input logic [3:0]  byte_count,
  input logic        last,
  input logic        block_end,
  input logic [1:0]  error_code
);

  logic [71:0] out_word;
  logic        flagged;

  assign out_word = {out_bytes, byte_count, last, block_end, error_code};
  assign flagged  = block_end || (error_code != ERR_OK);

  `LZBC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))
  `LZBC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `LZBC_ASSERT_IMPL(a_flag_empty, out_valid && flagged, byte_count == 4'd0 && last)
  `LZBC_ASSERT_IMPL(a_partial_final, out_valid && !last, byte_count == 4'(BYTES_PER_RESULT))

endmodule

bind lz77_backref_copy_engine_top lzbc_checker #(
  .BYTES_PER_RESULT (BYTES_PER_RESULT)
) u_lzbc_checker (.*);
